@@ rtl/hes_pkg.sv @@
// shared types and constants for the hysteresis event statistics core
package hes_pkg;

	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned DIV_STEPS = 32;

	localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
	localparam logic [14:0] OFFSET_RST = 15'd2500;
	localparam logic [14:0] HYST_RST   = 15'd350;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER = 2'd0,
		REG_UPPER  = 2'd1,
		REG_LOWER  = 2'd2,
		REG_HYST   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] filtered_level;
		logic signed [15:0] raw_sample;
	} in_item_t;

	typedef struct packed {
		logic               polarity;
		logic signed [15:0] mean_value;
		logic signed [15:0] peak_max;
		logic signed [15:0] peak_min;
		logic        [15:0] sample_count;
	} out_item_t;

	// finished excursion waiting for the mean divide
	typedef struct packed {
		logic               polarity;
		logic signed [31:0] sum;
		logic signed [15:0] peak_max;
		logic signed [15:0] peak_min;
		logic        [15:0] count;
	} evq_entry_t;

endpackage

@@ rtl/hysteresis_event_statistics_core.sv @@
// top level of the hysteresis event statistics core
//
//   channel  | ports                          | transfer when
//   ---------+--------------------------------+----------------------
//   input    | push, full, item               | push && !full
//   result   | empty, pop, result             | pop && !empty
//   config   | cfg_we, cfg_idx, cfg_data      | cfg_we
//
// an input item is classified combinationally and accumulated into registers; the front end
// takes one item per cycle as long as the excursion queue has room.
// in the back end each finished excursion is pulled from the queue, its mean is found by a
// serial divide, and the result register is loaded once it is free or being popped.
// full rises only when EVQ_DEPTH finished excursions wait for the divider.
// reset clears all control state and loads the register reset values.
module hysteresis_event_statistics_core #(
	parameter int unsigned EVQ_DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hes_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [hes_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           push,
	output logic                           full,
	input  hes_pkg::in_item_t              item,
	output logic                           empty,
	input  logic                           pop,
	output hes_pkg::out_item_t             result
);

	logic                evq_push;
	logic                evq_pop;
	logic                evq_full;
	logic                evq_empty;
	hes_pkg::evq_entry_t evq_wr;
	hes_pkg::evq_entry_t evq_rd;

	assign full = evq_full;

	hes_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.push      (push),
		.item      (item),
		.evq_full  (evq_full),
		.evq_push  (evq_push),
		.evq_entry (evq_wr)
	);

	hes_evq #(
		.DEPTH (EVQ_DEPTH)
	) u_evq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (evq_push),
		.wr_data (evq_wr),
		.rd_en   (evq_pop),
		.rd_data (evq_rd),
		.full    (evq_full),
		.empty   (evq_empty)
	);

	hes_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.evq_empty (evq_empty),
		.evq_entry (evq_rd),
		.evq_pop   (evq_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

@@ rtl/hes_front.sv @@
// front end: config registers, band compare and excursion accumulation
module hes_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hes_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [hes_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           push,
	input  hes_pkg::in_item_t              item,
	input  logic                           evq_full,
	output logic                           evq_push,
	output hes_pkg::evq_entry_t            evq_entry
);

	typedef enum logic [1:0] {
		RG_IDLE  = 2'd0,
		RG_ABOVE = 2'd1,
		RG_BELOW = 2'd2
	} region_t;

	logic signed [15:0] center_q;
	logic        [14:0] upper_q;
	logic        [14:0] lower_q;
	logic        [14:0] hyst_q;

	region_t            region_q;
	logic               widened_q;
	logic signed [31:0] sum_q;
	logic signed [15:0] max_q;
	logic signed [15:0] min_q;
	logic        [15:0] count_q;

	logic        [14:0] widen;
	logic signed [17:0] center_x;
	logic signed [17:0] level_x;
	logic signed [17:0] up_thr;
	logic signed [17:0] lo_thr;
	logic               up_hit;
	logic               dn_hit;
	logic               take;
	logic signed [31:0] raw_x;

	assign widen    = widened_q ? hyst_q : 15'd0;
	assign center_x = 18'(center_q);
	assign level_x  = 18'(item.filtered_level);
	assign up_thr   = center_x + $signed({3'b000, upper_q}) - $signed({3'b000, widen});
	assign lo_thr   = center_x - $signed({3'b000, lower_q}) + $signed({3'b000, widen});
	assign up_hit   = (region_q == RG_IDLE || region_q == RG_ABOVE) && (level_x > up_thr);
	assign dn_hit   = (region_q == RG_IDLE || region_q == RG_BELOW) && (level_x < lo_thr);
	assign take     = push && !evq_full;
	assign raw_x    = 32'(item.raw_sample);

	// an active excursion ends when neither test keeps it going
	assign evq_push = take && !up_hit && !dn_hit &&
		(region_q == RG_ABOVE || region_q == RG_BELOW);

	always_comb begin
		evq_entry.polarity = (region_q == RG_BELOW);
		evq_entry.sum      = sum_q;
		evq_entry.peak_max = max_q;
		evq_entry.peak_min = min_q;
		evq_entry.count    = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			upper_q  <= hes_pkg::OFFSET_RST;
			lower_q  <= hes_pkg::OFFSET_RST;
			hyst_q   <= hes_pkg::HYST_RST;
		end else if (cfg_we) begin
			unique case (hes_pkg::cfg_reg_t'(cfg_idx))
				hes_pkg::REG_CENTER: center_q <= $signed(cfg_data);
				hes_pkg::REG_UPPER:  upper_q  <= cfg_data[14:0];
				hes_pkg::REG_LOWER:  lower_q  <= cfg_data[14:0];
				hes_pkg::REG_HYST:   hyst_q   <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q  <= RG_IDLE;
			widened_q <= 1'b0;
			sum_q     <= '0;
			max_q     <= '0;
			min_q     <= '0;
			count_q   <= '0;
		end else if (take) begin
			if (up_hit || dn_hit) begin
				if (region_q == RG_IDLE) begin
					region_q  <= up_hit ? RG_ABOVE : RG_BELOW;
					widened_q <= 1'b1;
					sum_q     <= raw_x;
					max_q     <= item.raw_sample;
					min_q     <= item.raw_sample;
					count_q   <= 16'd1;
				end else begin
					// sum stops with the count so the mean stays in range
					if (count_q != hes_pkg::COUNT_MAX) begin
						sum_q   <= sum_q + raw_x;
						count_q <= count_q + 16'd1;
					end
					if (item.raw_sample > max_q)
						max_q <= item.raw_sample;
					if (item.raw_sample < min_q)
						min_q <= item.raw_sample;
				end
			end else begin
				region_q  <= RG_IDLE;
				widened_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/hes_evq.sv @@
// short queue of finished excursions between front end and divider
module hes_evq #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  hes_pkg::evq_entry_t wr_data,
	input  logic                rd_en,
	output hes_pkg::evq_entry_t rd_data,
	output logic                full,
	output logic                empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	hes_pkg::evq_entry_t slots_q [DEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [CW-1:0]       cnt_q;
	logic                do_wr;
	logic                do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			slots_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

@@ rtl/hes_div.sv @@
// back end: serial mean divide and result register
module hes_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                evq_empty,
	input  hes_pkg::evq_entry_t evq_entry,
	output logic                evq_pop,
	output hes_pkg::out_item_t  result,
	output logic                empty,
	input  logic                pop
);

	localparam int unsigned SW = $clog2(hes_pkg::DIV_STEPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t             state_q;
	logic [SW-1:0]      step_q;
	hes_pkg::out_item_t res_q;
	logic               res_valid_q;

	logic [31:0]        quo_q;
	logic [15:0]        rem_q;
	logic [15:0]        divisor_q;
	logic               neg_q;
	logic               pol_q;
	logic signed [15:0] max_q;
	logic signed [15:0] min_q;

	logic [31:0]        sum_abs;
	logic [16:0]        rem_sh;
	logic               fits;
	logic [16:0]        rem_sub;
	logic [15:0]        mag;
	logic signed [15:0] mean;
	logic               load_res;

	assign sum_abs = evq_entry.sum[31] ? 32'(-evq_entry.sum) : evq_entry.sum;
	assign rem_sh  = {rem_q, quo_q[31]};
	assign fits    = (rem_sh >= {1'b0, divisor_q});
	assign rem_sub = rem_sh - {1'b0, divisor_q};
	assign mag     = quo_q[15:0];
	assign mean    = (divisor_q == '0) ? '0 : (neg_q ? $signed(16'(-mag)) : $signed(mag));

	assign evq_pop  = (state_q == ST_IDLE) && !evq_empty;
	assign load_res = (state_q == ST_HOLD) && (!res_valid_q || pop);
	assign result   = res_q;
	assign empty    = !res_valid_q;

	// restoring divide, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (evq_pop) begin
			quo_q     <= sum_abs;
			rem_q     <= '0;
			divisor_q <= evq_entry.count;
			neg_q     <= evq_entry.sum[31];
			pol_q     <= evq_entry.polarity;
			max_q     <= evq_entry.peak_max;
			min_q     <= evq_entry.peak_min;
		end else if (state_q == ST_DIV) begin
			rem_q <= fits ? rem_sub[15:0] : rem_sh[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_res) begin
				res_q.polarity     <= pol_q;
				res_q.mean_value   <= mean;
				res_q.peak_max     <= max_q;
				res_q.peak_min     <= min_q;
				res_q.sample_count <= divisor_q;
				res_valid_q        <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!evq_empty) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(hes_pkg::DIV_STEPS - 1))
						state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (load_res)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/hes_chk.sv @@
// port-level checker for the hysteresis event statistics core, with its bind
module hes_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input hes_pkg::out_item_t result
);

	// queue and result register are clear while reset is held
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |-> (empty && !full))
		else $error("core not cleared in reset");

	// the queue can only fill up from an input transfer
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an input transfer");

	// a waiting result holds until its transfer
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while stalled");

	// a truncated mean always lies between the peaks
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.sample_count != 16'd0 &&
			result.peak_min <= result.peak_max &&
			result.mean_value >= result.peak_min &&
			result.mean_value <= result.peak_max))
		else $error("result statistics inconsistent");

endmodule

bind hysteresis_event_statistics_core hes_chk u_hes_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

@@ verif/hes_checker.sv @@
// checker for the hysteresis event statistics core: excursion predictor and result compare
module hes_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hes_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [hes_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          push,
	input  logic                          full,
	input  hes_pkg::in_item_t             item,
	input  logic                          empty,
	input  logic                          pop,
	input  hes_pkg::out_item_t            result,
	output int                            fails,
	output int                            pending
);

	typedef enum logic [1:0] {
		EXC_NONE  = 2'd0,
		EXC_ABOVE = 2'd1,
		EXC_BELOW = 2'd2
	} excursion_t;

	logic signed [15:0] center;
	logic        [14:0] up_off;
	logic        [14:0] lo_off;
	logic        [14:0] hyst;
	excursion_t         exc;
	logic               widened;
	logic signed [31:0] ev_sum;
	logic signed [15:0] ev_max;
	logic signed [15:0] ev_min;
	logic        [15:0] ev_cnt;
	hes_pkg::out_item_t expected_events[$];

	task automatic compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	task automatic track_sample(hes_pkg::in_item_t it);
		int                 w;
		int                 up_thr;
		int                 lo_thr;
		int                 quo;
		excursion_t         dir;
		hes_pkg::out_item_t ev;
		w      = widened ? int'(hyst) : 0;
		up_thr = int'(center) + int'(up_off) - w;
		lo_thr = int'(center) - int'(lo_off) + w;
		if (exc != EXC_BELOW && int'(it.filtered_level) > up_thr)
			dir = EXC_ABOVE;
		else if (exc != EXC_ABOVE && int'(it.filtered_level) < lo_thr)
			dir = EXC_BELOW;
		else
			dir = EXC_NONE;

		if (dir != EXC_NONE && exc == EXC_NONE) begin
			ev_sum = it.raw_sample;
			ev_max = it.raw_sample;
			ev_min = it.raw_sample;
			ev_cnt = 16'd1;
		end else if (dir != EXC_NONE) begin
			// sum freezes together with the saturated count
			if (ev_cnt != hes_pkg::COUNT_MAX) begin
				ev_sum += it.raw_sample;
				ev_cnt++;
			end
			if (it.raw_sample > ev_max)
				ev_max = it.raw_sample;
			if (it.raw_sample < ev_min)
				ev_min = it.raw_sample;
		end else if (exc != EXC_NONE) begin
			quo = (ev_cnt == 16'd0) ? 0 : ev_sum / int'(ev_cnt);
			ev.polarity     = (exc == EXC_BELOW);
			ev.mean_value   = quo[15:0];
			ev.peak_max     = ev_max;
			ev.peak_min     = ev_min;
			ev.sample_count = ev_cnt;
			expected_events.push_back(ev);
		end
		exc     = dir;
		widened = (dir != EXC_NONE);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		hes_pkg::out_item_t want;
		if (!arst_n) begin
			center  = '0;
			up_off  = hes_pkg::OFFSET_RST;
			lo_off  = hes_pkg::OFFSET_RST;
			hyst    = hes_pkg::HYST_RST;
			exc     = EXC_NONE;
			widened = 1'b0;
			ev_sum  = '0;
			ev_max  = '0;
			ev_min  = '0;
			ev_cnt  = '0;
			expected_events.delete();
		end else begin
			if (cfg_we) begin
				case (hes_pkg::cfg_reg_t'(cfg_idx))
					hes_pkg::REG_CENTER: center = cfg_data;
					hes_pkg::REG_UPPER:  up_off = cfg_data[14:0];
					hes_pkg::REG_LOWER:  lo_off = cfg_data[14:0];
					hes_pkg::REG_HYST:   hyst   = cfg_data[14:0];
					default: ;
				endcase
			end
			// results leave before a new item can add an event in the same cycle
			if (pop && !empty) begin
				if (expected_events.size() == 0) begin
					fails++;
					$display("%0t: result expected none got %h", $time, result);
				end else begin
					want = expected_events.pop_front();
					compare_field("polarity", want.polarity, result.polarity);
					compare_field("mean_value", want.mean_value, result.mean_value);
					compare_field("peak_max", want.peak_max, result.peak_max);
					compare_field("peak_min", want.peak_min, result.peak_min);
					compare_field("sample_count", want.sample_count, result.sample_count);
				end
			end
			if (push && !full)
				track_sample(item);
		end
		pending = expected_events.size();
	end

endmodule

@@ verif/tb_hysteresis_event_statistics_core.sv @@
// testbench top for the hysteresis event statistics core: stimulus, reset and verdict
module tb_hysteresis_event_statistics_core;

	localparam int LIMIT  = 1_000_000;
	localparam int SETTLE = 40;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [hes_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [hes_pkg::CFG_W-1:0]     cfg_data;
	logic                          push;
	logic                          full;
	hes_pkg::in_item_t             item;
	logic                          empty;
	logic                          pop;
	hes_pkg::out_item_t            result;

	int fails;
	int pending;
	int cycles;
	int sent;
	// band settings as last written, used to aim the levels
	int c_lvl;
	int u_off;
	int l_off;
	int h_wid;
	bit burst_in;
	bit burst_out;

	hysteresis_event_statistics_core u_top (.*);

	hes_checker u_chk (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int level_in(int lo, int hi);
		if (lo < -32768)
			lo = -32768;
		if (hi > 32767)
			hi = 32767;
		if (lo > hi)
			return int'($urandom_range(0, 65535)) - 32768;
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic int raw_pick();
		case ($urandom_range(0, 7))
			0: return 32767;
			1: return -32768;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// level beyond the band edge, or only within the hysteresis margin when shallow
	function automatic int outside(bit down, bit shallow);
		if (down)
			return shallow ? level_in(c_lvl - l_off, c_lvl - l_off + h_wid - 1)
			               : level_in(-32768, c_lvl - l_off - 1);
		return shallow ? level_in(c_lvl + u_off - h_wid + 1, c_lvl + u_off)
		               : level_in(c_lvl + u_off + 1, 32767);
	endfunction

	task automatic send(int lvl, int smp);
		int gap;
		gap = burst_in ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.filtered_level <= lvl[15:0];
		item.raw_sample     <= smp[15:0];
		push                <= 1'b1;
		do @(posedge clk); while (full);
		sent++;
	endtask

	task automatic excursion(bit down, int len);
		int i;
		send(outside(down, 1'b0), raw_pick());
		for (i = 1; i < len; i++)
			send(outside(down, $urandom_range(0, 2) == 0), raw_pick());
		if ($urandom_range(0, 3) == 0)
			send(outside(!down, 1'b0), raw_pick());
		else
			send(level_in(c_lvl - l_off + h_wid, c_lvl + u_off - h_wid), raw_pick());
	endtask

	task automatic settle();
		push <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(hes_pkg::cfg_reg_t r, logic [15:0] d);
		cfg_we   <= 1'b1;
		cfg_idx  <= r;
		cfg_data <= d;
		@(posedge clk);
	endtask

	// bit 15 of the offset and hysteresis writes is junk the block must drop
	task automatic configure(int c, int u, int l, int h);
		write_reg(hes_pkg::REG_CENTER, c[15:0]);
		write_reg(hes_pkg::REG_UPPER, {$urandom_range(0, 1) != 0, u[14:0]});
		write_reg(hes_pkg::REG_LOWER, {$urandom_range(0, 1) != 0, l[14:0]});
		write_reg(hes_pkg::REG_HYST, {$urandom_range(0, 1) != 0, h[14:0]});
		cfg_we <= 1'b0;
		c_lvl = c;
		u_off = u;
		l_off = l;
		h_wid = h;
	endtask

	task automatic run_phase(int n);
		int stop;
		stop      = sent + n;
		burst_in  = $urandom_range(0, 3) == 0;
		burst_out = $urandom_range(0, 3) == 0;
		while (sent < stop) begin
			if ($urandom_range(0, 4) == 0)
				send(level_in(-32768, 32767), raw_pick());
			else
				excursion($urandom_range(0, 1) != 0, $urandom_range(1, 12));
		end
		settle();
	endtask

	initial begin : drain
		int gap;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = burst_out ? 0 : $urandom_range(0, 15);
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	initial begin : stimulus
		arst_n   <= 1'b0;
		push     <= 1'b0;
		cfg_we   <= 1'b0;
		cfg_idx  <= hes_pkg::REG_CENTER;
		cfg_data <= '0;
		item     <= '0;
		c_lvl = 0;
		u_off = 2500;
		l_off = 2500;
		h_wid = 350;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// band edges and hysteresis margin at the reset values
		send(2500, 100);
		send(2501, 32767);
		send(2151, -32768);
		send(2150, 5);
		send(-2500, 7);
		send(-2501, -32768);
		send(-2151, -32768);
		send(-2151, -3);
		send(-2150, 0);
		// straight reversal ends one excursion, the next starts a step later
		send(32767, 1);
		send(-32768, 2);
		send(-32768, -1);
		send(32767, 3);
		// one-sample excursion, then a negative mean that must truncate toward zero
		send(32767, 4);
		send(0, 0);
		send(-3000, -3);
		send(-3000, -4);
		send(0, 0);
		run_phase(100);

		configure(32767, 32767, 32767, 32767);
		run_phase(100);
		configure(-32768, 0, 0, 0);
		run_phase(100);
		configure(-32768, 32767, 32767, 32767);
		run_phase(100);
		configure(32767, 0, 0, 0);
		run_phase(100);
		repeat (3) begin
			configure(int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 6000),
			          $urandom_range(0, 6000), $urandom_range(0, 3000));
			run_phase(130);
		end

		if (fails == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ hysteresis_event_statistics_core.f @@
rtl/hes_pkg.sv
rtl/hes_front.sv
rtl/hes_evq.sv
rtl/hes_div.sv
rtl/hysteresis_event_statistics_core.sv
rtl/hes_chk.sv
verif/hes_checker.sv
verif/tb_hysteresis_event_statistics_core.sv
